/* hdl/camera_view_matrix_defines.svh */
// Assertion macros for the camera view matrix block.
// Used by camera_view_matrix.sv; expect clk and rst in the including scope.
`ifndef CAMERA_VIEW_MATRIX_DEFINES_SVH
`define CAMERA_VIEW_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
`define CVM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("camera_view_matrix: check failed");
`define CVM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("camera_view_matrix: check failed");
`define CVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("camera_view_matrix: check failed");
`else
`define CVM_ASSERT(lbl, expr)
`define CVM_ASSERT_IMPL(lbl, ante, cons)
`define CVM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/cvm_pkg.sv */
// Shared types and constants for the camera view matrix block.
// No dependencies; used by cvm_norm and camera_view_matrix.
`default_nettype none
package cvm_pkg;
  localparam int NORM_LAT = 69;
  localparam int TOP_LAT  = NORM_LAT + 14;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [47:0] q18_t;
  typedef logic signed [32:0] diff_t;

  typedef struct packed {
    q30_t m00;
    q30_t m01;
    q30_t m02;
    q18_t m03;
    q30_t m10;
    q30_t m11;
    q30_t m12;
    q18_t m13;
    q30_t m20;
    q30_t m21;
    q30_t m22;
    q18_t m23;
  } result_t;
endpackage
`default_nettype wire

/* hdl/cvm_norm.sv */
// Pipelined 3-vector normaliser: block scaling, sum of squares, 32-stage
// integer square root and 31-stage restoring divider. Depends on cvm_pkg.
`default_nettype none
module cvm_norm (
  input  logic          clk,
  input  logic          ce,
  input  cvm_pkg::diff_t comp [3],
  output cvm_pkg::q30_t  vec  [3]
);
  import cvm_pkg::*;

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 31;

  function automatic logic [4:0] msb_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) p = 5'(k);
    end
    return p;
  endfunction

  logic [31:0] mag_c [3];
  logic [31:0] mag1  [3];
  logic        neg1  [3];
  logic [31:0] or1;
  logic [30:0] sc2   [3];
  logic        neg2  [3];
  logic        zero2;
  logic [4:0]  p2c;
  logic [61:0] sq3   [3];
  logic [30:0] sc3   [3];
  logic        neg3  [3];
  logic        zero3;

  logic [63:0] srem  [SQ_STEPS+1];
  logic [63:0] sroot [SQ_STEPS+1];
  logic [30:0] sm    [SQ_STEPS+1][3];
  logic        sneg  [SQ_STEPS+1][3];
  logic        szero [SQ_STEPS+1];
  logic [63:0] trial [SQ_STEPS];
  logic        sge   [SQ_STEPS];

  logic [61:0] num_c [3];
  logic [31:0] drem  [DIV_STEPS+1][3];
  logic [30:0] dlow  [DIV_STEPS+1][3];
  logic [30:0] dq    [DIV_STEPS+1][3];
  logic [31:0] dlen  [DIV_STEPS+1];
  logic        dneg  [DIV_STEPS+1][3];
  logic        dzero [DIV_STEPS+1];
  logic [32:0] dt    [DIV_STEPS][3];
  logic        dge   [DIV_STEPS][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = comp[i][32] ? 32'(-comp[i]) : comp[i][31:0];
    end
    p2c = msb_pos(or1);
    for (int k = 0; k < SQ_STEPS; k++) begin
      trial[k] = sroot[k] + (64'd1 << (62 - 2 * k));
      sge[k]   = srem[k] >= trial[k];
    end
    for (int i = 0; i < 3; i++) begin
      num_c[i] = 62'({sm[SQ_STEPS][i], 30'd0}) + 62'(sroot[SQ_STEPS][31:1]);
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        dt[j][i]  = {drem[j][i], dlow[j][i][30]};
        dge[j][i] = dt[j][i] >= {1'b0, dlen[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      // magnitudes; the OR shares its top bit with the largest one
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag_c[i];
        neg1[i] <= comp[i][32];
      end
      or1 <= mag_c[0] | mag_c[1] | mag_c[2];

      // block scale so the largest lands in [2^30, 2^31)
      for (int i = 0; i < 3; i++) begin
        sc2[i]  <= (p2c == 5'd31) ? 31'(mag1[i] >> 1) : 31'(mag1[i] << (5'd30 - p2c));
        neg2[i] <= neg1[i];
      end
      zero2 <= (or1 == '0);

      for (int i = 0; i < 3; i++) begin
        sq3[i]  <= 62'(sc2[i]) * 62'(sc2[i]);
        sc3[i]  <= sc2[i];
        neg3[i] <= neg2[i];
      end
      zero3 <= zero2;

      srem[0]  <= 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]);
      sroot[0] <= '0;
      sm[0]    <= sc3;
      sneg[0]  <= neg3;
      szero[0] <= zero3;

      for (int k = 0; k < SQ_STEPS; k++) begin
        if (sge[k]) begin
          srem[k+1]  <= srem[k] - trial[k];
          sroot[k+1] <= (sroot[k] >> 1) + (64'd1 << (62 - 2 * k));
        end else begin
          srem[k+1]  <= srem[k];
          sroot[k+1] <= sroot[k] >> 1;
        end
        sm[k+1]    <= sm[k];
        sneg[k+1]  <= sneg[k];
        szero[k+1] <= szero[k];
      end

      // rounded quotient: (m * 2^30 + len/2) / len
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= {1'b0, num_c[i][61:31]};
        dlow[0][i] <= num_c[i][30:0];
        dq[0][i]   <= '0;
        dneg[0][i] <= sneg[SQ_STEPS][i];
      end
      dlen[0]  <= sroot[SQ_STEPS][31:0];
      dzero[0] <= szero[SQ_STEPS];

      for (int j = 0; j < DIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          drem[j+1][i] <= dge[j][i] ? 32'(dt[j][i] - {1'b0, dlen[j]}) : dt[j][i][31:0];
          dlow[j+1][i] <= {dlow[j][i][29:0], 1'b0};
          dq[j+1][i]   <= {dq[j][i][29:0], dge[j][i]};
          dneg[j+1][i] <= dneg[j][i];
        end
        dlen[j+1]  <= dlen[j];
        dzero[j+1] <= dzero[j];
      end

      for (int i = 0; i < 3; i++) begin
        if (dzero[DIV_STEPS]) begin
          vec[i] <= '0;
        end else if (dneg[DIV_STEPS][i]) begin
          vec[i] <= -q30_t'({1'b0, dq[DIV_STEPS][i]});
        end else begin
          vec[i] <= q30_t'({1'b0, dq[DIV_STEPS][i]});
        end
      end
    end
  end
endmodule
`default_nettype wire

/* hdl/camera_view_matrix.sv */
// Look-at camera view matrix, top level: input stage, two normalisers,
// two cross products, translation dot products, output buffer.
// Depends on cvm_pkg, cvm_norm and camera_view_matrix_defines.svh.
`default_nettype none
`include "camera_view_matrix_defines.svh"
// Takes one eye/target/up transaction per clock while the pipeline is not
// held and returns rows 0 to 2 of the view matrix for each. Most of the
// pipeline lies in the normalisers: a 32-stage square root and a 31-stage
// divider, one step per stage. A two-entry output buffer lets input
// continue while a result waits; the whole pipeline holds only when that
// buffer is full and the result is not taken.
module camera_view_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  eye_x,
  input  logic signed [31:0]  eye_y,
  input  logic signed [31:0]  eye_z,
  input  logic signed [31:0]  target_x,
  input  logic signed [31:0]  target_y,
  input  logic signed [31:0]  target_z,
  input  logic signed [31:0]  upward_x,
  input  logic signed [31:0]  upward_y,
  input  logic signed [31:0]  upward_z,
  output logic                out_valid,
  input  logic                out_ready,
  output cvm_pkg::q30_t       m00,
  output cvm_pkg::q30_t       m01,
  output cvm_pkg::q30_t       m02,
  output cvm_pkg::q18_t       m03,
  output cvm_pkg::q30_t       m10,
  output cvm_pkg::q30_t       m11,
  output cvm_pkg::q30_t       m12,
  output cvm_pkg::q18_t       m13,
  output cvm_pkg::q30_t       m20,
  output cvm_pkg::q30_t       m21,
  output cvm_pkg::q30_t       m22,
  output cvm_pkg::q18_t       m23
);
  import cvm_pkg::*;

  localparam int EYE_D = NORM_LAT + 8;

  logic               ce;
  logic [TOP_LAT-1:0] vpipe;

  logic signed [31:0] eye0 [3];
  logic signed [31:0] tgt0 [3];
  logic signed [31:0] upw0 [3];
  diff_t              dir1 [3];
  diff_t              up1  [3];
  logic signed [31:0] eye1 [3];
  q30_t               f_n  [3];
  q30_t               u_n  [3];

  logic signed [31:0] eye_d [EYE_D][3];
  q30_t               fd    [12][3];
  q30_t               ld    [8][3];
  q30_t               td    [4][3];

  q30_t               ca   [2][3];
  q30_t               cb   [2][3];
  logic signed [63:0] cp1  [2][3];
  logic signed [63:0] cp2  [2][3];
  logic signed [63:0] cd   [2][3];
  logic [63:0]        cmag [2][3];
  logic [32:0]        cr   [2][3];
  logic               cs   [2][3];
  q30_t               csat [2][3];
  q30_t               co   [2][3];

  q30_t               row  [3][3];
  logic signed [63:0] dp   [3][3];
  logic signed [63:0] ds   [3];
  logic [63:0]        dmag [3];
  logic [47:0]        dr   [3];
  logic               dneg [3];
  q18_t               dout [3];

  logic       push;
  logic       pop;
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  result_t    fe [2];
  result_t    push_d;

  assign ce       = (cnt != 2'd2) || out_ready;
  assign in_ready = ce;
  assign push     = ce && vpipe[TOP_LAT-1];
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (ce) begin
      vpipe <= {vpipe[TOP_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      eye0[0] <= eye_x;
      eye0[1] <= eye_y;
      eye0[2] <= eye_z;
      tgt0[0] <= target_x;
      tgt0[1] <= target_y;
      tgt0[2] <= target_z;
      upw0[0] <= upward_x;
      upw0[1] <= upward_y;
      upw0[2] <= upward_z;
      for (int i = 0; i < 3; i++) begin
        dir1[i] <= diff_t'(tgt0[i]) - diff_t'(eye0[i]);
        up1[i]  <= diff_t'(upw0[i]);
        eye1[i] <= eye0[i];
      end
    end
  end

  cvm_norm u_norm_fwd (
    .clk  (clk),
    .ce   (ce),
    .comp (dir1),
    .vec  (f_n)
  );

  cvm_norm u_norm_up (
    .clk  (clk),
    .ce   (ce),
    .comp (up1),
    .vec  (u_n)
  );

  // alignment delays for eye, forward, left and true up
  always_ff @(posedge clk) begin
    if (ce) begin
      eye_d[0] <= eye1;
      for (int k = 1; k < EYE_D; k++) eye_d[k] <= eye_d[k-1];
      fd[0] <= f_n;
      for (int k = 1; k < 12; k++) fd[k] <= fd[k-1];
      ld[0] <= co[0];
      for (int k = 1; k < 8; k++) ld[k] <= ld[k-1];
      td[0] <= co[1];
      for (int k = 1; k < 4; k++) td[k] <= td[k-1];
    end
  end

  // cross product 0: left = f x u; cross product 1: true up = left x f
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[0][i] = f_n[i];
      cb[0][i] = u_n[i];
      ca[1][i] = co[0][i];
      cb[1][i] = fd[3][i];
    end
    for (int g = 0; g < 2; g++) begin
      for (int i = 0; i < 3; i++) begin
        cmag[g][i] = cd[g][i][63] ? 64'(-cd[g][i]) : 64'(cd[g][i]);
        csat[g][i] = (cr[g][i] > 33'(ONE_Q30)) ? ONE_Q30 : q30_t'(cr[g][i][31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int g = 0; g < 2; g++) begin
        for (int i = 0; i < 3; i++) begin
          cp1[g][i] <= 64'(ca[g][(i + 1) % 3]) * 64'(cb[g][(i + 2) % 3]);
          cp2[g][i] <= 64'(ca[g][(i + 2) % 3]) * 64'(cb[g][(i + 1) % 3]);
          cd[g][i]  <= cp1[g][i] - cp2[g][i];
          cr[g][i]  <= 33'((cmag[g][i] + (64'd1 << 29)) >> 30);
          cs[g][i]  <= cd[g][i][63];
          co[g][i]  <= cs[g][i] ? -csat[g][i] : csat[g][i];
        end
      end
    end
  end

  // translation: minus each row dotted with the eye point
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      row[0][c] = ld[3][c];
      row[1][c] = co[1][c];
      row[2][c] = -fd[7][c];
    end
    for (int r = 0; r < 3; r++) begin
      dmag[r] = ds[r][63] ? 64'(-ds[r]) : 64'(ds[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          dp[r][c] <= 64'(row[r][c]) * 64'(eye_d[EYE_D-1][c]);
        end
        ds[r]   <= dp[r][0] + dp[r][1] + dp[r][2];
        dr[r]   <= 48'((dmag[r] + (64'd1 << 15)) >> 16);
        dneg[r] <= !ds[r][63] && (ds[r] != '0);
        dout[r] <= dneg[r] ? -q18_t'(dr[r]) : q18_t'(dr[r]);
      end
    end
  end

  always_comb begin
    push_d.m00 = ld[7][0];
    push_d.m01 = ld[7][1];
    push_d.m02 = ld[7][2];
    push_d.m03 = dout[0];
    push_d.m10 = td[3][0];
    push_d.m11 = td[3][1];
    push_d.m12 = td[3][2];
    push_d.m13 = dout[1];
    push_d.m20 = -fd[11][0];
    push_d.m21 = -fd[11][1];
    push_d.m22 = -fd[11][2];
    push_d.m23 = dout[2];
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fe[wp] <= push_d;
  end

  assign out_valid = (cnt != 2'd0);
  assign m00 = fe[rp].m00;
  assign m01 = fe[rp].m01;
  assign m02 = fe[rp].m02;
  assign m03 = fe[rp].m03;
  assign m10 = fe[rp].m10;
  assign m11 = fe[rp].m11;
  assign m12 = fe[rp].m12;
  assign m13 = fe[rp].m13;
  assign m20 = fe[rp].m20;
  assign m21 = fe[rp].m21;
  assign m22 = fe[rp].m22;
  assign m23 = fe[rp].m23;

  `CVM_ASSERT(a_cnt_range, cnt != 2'd3)
  `CVM_ASSERT_NEXT(a_stall_hold, !ce, $stable(vpipe))
  `CVM_ASSERT_IMPL(a_no_overflow, push && (cnt == 2'd2), pop)
  `CVM_ASSERT_IMPL(a_left_range, out_valid, (m00 <= ONE_Q30) && (m00 >= -ONE_Q30))
  `CVM_ASSERT_IMPL(a_up_range, out_valid, (m11 <= ONE_Q30) && (m11 >= -ONE_Q30))
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for camera_view_matrix (look-at view matrix).
// Depends on cvm_pkg; predicts each result in fixed point and checks rows 0..2.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = TOP_LAT + 20;
  localparam int HOLD_LEN       = 400;

  typedef longint vec3_t [3];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [31:0] upward_x = '0, upward_y = '0, upward_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  q30_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  q18_t m03, m13, m23;

  result_t matrix_q[$];
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  bit      hold_start = 1'b0;
  int      hold_cycles = 0;
  int      quiet_cycles = 0;
  bit      failed = 1'b0;

  always #1 clk = ~clk;

  camera_view_matrix dut (.*);

  // ---------------- fixed-point look-at predictor ----------------
  function automatic longint round_half_away(longint v, int sh);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned rem, root, bit_w;
    rem = n; root = 0; bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem -= root + bit_w;
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  function automatic void unit_vector(input vec3_t v, output vec3_t o);
    longint unsigned m[3], big, sum, len, q;
    int sh;
    big = 0; sum = 0; sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (big >= (64'd1 << 31)) begin big >>= 1; sh--; end
    while (big < (64'd1 << 30)) begin big <<= 1; sh++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = sh >= 0 ? m[i] << sh : m[i] >> (-sh);
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic void cross_q30(input vec3_t a, input vec3_t b, output vec3_t o);
    o[0] = clamp_unit(round_half_away(a[1] * b[2] - a[2] * b[1], 30));
    o[1] = clamp_unit(round_half_away(a[2] * b[0] - a[0] * b[2], 30));
    o[2] = clamp_unit(round_half_away(a[0] * b[1] - a[1] * b[0], 30));
  endfunction

  function automatic longint translation(vec3_t row, vec3_t eye);
    return round_half_away(-(row[0] * eye[0] + row[1] * eye[1] + row[2] * eye[2]), 16);
  endfunction

  function automatic result_t view_matrix(vec3_t eye, vec3_t tgt, vec3_t up);
    vec3_t dir, f, u, l, t, nf;
    result_t r;
    for (int i = 0; i < 3; i++) begin
      dir[i] = tgt[i] - eye[i];
    end
    unit_vector(dir, f);
    unit_vector(up, u);
    cross_q30(f, u, l);
    cross_q30(l, f, t);
    for (int i = 0; i < 3; i++) nf[i] = -f[i];
    r.m00 = q30_t'(l[0]);  r.m01 = q30_t'(l[1]);  r.m02 = q30_t'(l[2]);
    r.m03 = q18_t'(translation(l, eye));
    r.m10 = q30_t'(t[0]);  r.m11 = q30_t'(t[1]);  r.m12 = q30_t'(t[2]);
    r.m13 = q18_t'(translation(t, eye));
    r.m20 = q30_t'(nf[0]); r.m21 = q30_t'(nf[1]); r.m22 = q30_t'(nf[2]);
    r.m23 = q18_t'(translation(nf, eye));
    return r;
  endfunction

  function automatic void flatten(input result_t r, output longint f[12]);
    f = '{longint'(r.m00), longint'(r.m01), longint'(r.m02), longint'(r.m03),
          longint'(r.m10), longint'(r.m11), longint'(r.m12), longint'(r.m13),
          longint'(r.m20), longint'(r.m21), longint'(r.m22), longint'(r.m23)};
  endfunction

  // ---------------- stimulus ----------------
  task automatic send_view(int ex, int ey, int ez, int tx, int ty, int tz,
                           int ux, int uy, int uz);
    int gap;
    in_valid <= 1'b1;
    eye_x <= ex; eye_y <= ey; eye_z <= ez;
    target_x <= tx; target_y <= ty; target_z <= tz;
    upward_x <= ux; upward_y <= uy; upward_z <= uz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    matrix_q.push_back(view_matrix('{ex, ey, ez}, '{tx, ty, tz}, '{ux, uy, uz}));
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
      2: return $signed($urandom_range(16)) - 8;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic send_random();
    int e[3], t[3], u[3];
    int mode, shape;
    mode = $urandom_range(9) < 5 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
    for (int i = 0; i < 3; i++) begin
      e[i] = rand_coord($urandom_range(15) == 0 ? 3 : mode);
      t[i] = rand_coord($urandom_range(15) == 0 ? 3 : mode);
      u[i] = rand_coord($urandom_range(15) == 0 ? 3 : mode);
    end
    shape = $urandom_range(19);
    if (shape == 0) t = e;                          // degenerate direction
    if (shape == 1) u = '{0, 0, 0};                 // degenerate up
    if (shape == 2) for (int i = 0; i < 3; i++) u[i] = t[i] - e[i]; // up along view
    send_view(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int mx, mn, one;
    mx = 32'h7FFF_FFFF; mn = 32'h8000_0000; one = 32'h0001_0000;
    sender_idle_pct = 0; receiver_stall_pct = 0;
    send_view(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_view(0, 0, 0, 0, 0, -one, 0, one, 0);
    send_view(one, 2 * one, 3 * one, one, 2 * one, 3 * one, 0, one, 0);
    send_view(0, 0, 0, 0, 0, -one, 0, 0, 0);
    send_view(0, 0, 0, 0, one, 0, 0, 5 * one, 0);
    send_view(mn, mn, mn, mx, mx, mx, 0, one, 0);
    send_view(mx, mx, mx, mn, mn, mn, mx, mn, mx);
    send_view(mx, mn, mx, mn, mx, mn, mn, mn, mn);
    send_view(mn, mx, 0, mx, mn, 1, 1, 1, 1);
    send_view(0, 0, 0, 1, 0, 0, 0, 0, 1);
    send_view(0, 0, 0, -1, -1, -1, -1, 0, 0);
    send_view(mx, mx, mx, 0, 0, 0, mn, 0, 0);
    send_view(-1, -1, -1, mx, mx, mx, mx, mx, mx);
    send_view(mn, 0, 0, mn, 0, one, mx, mx, 0);
    send_view(3 * one, -one, 7, 3 * one, -one, 8, 1, -1, 0);
    send_view(0, mn, 0, 0, mx, 0, 0, mx, 0);
    wait_drained();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct; receiver_stall_pct = stall_pct;
    repeat (n) send_random();
  endtask

  // Receiver stops for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    sender_idle_pct = 0; receiver_stall_pct = 0;
    hold_start = 1'b1;
    repeat (150) send_random();
    wait_drained();
  endtask

  // ---------------- receiver, checker, watchdog ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_start && hold_cycles < HOLD_LEN) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready <= $urandom_range(99) >= receiver_stall_pct;
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    longint g[12], w[12];
    string   names[12];
    names = '{"m00", "m01", "m02", "m03", "m10", "m11", "m12", "m13",
              "m20", "m21", "m22", "m23"};
    if (!rst && out_valid && out_ready) begin
      got = '{m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23};
      if (matrix_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $time);
        failed = 1'b1;
      end else begin
        want = matrix_q.pop_front();
        flatten(got, g);
        flatten(want, w);
        for (int i = 0; i < 12; i++)
          if (g[i] != w[i]) begin
            $display("%0t: %s expected %0d actual %0d", $time, names[i], w[i], g[i]);
            failed = 1'b1;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0);
    test_random(220, 59, 0);
    test_random(220, 0, 59);
    test_random(220, 38, 38);
    test_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && matrix_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
